// File: rtl/dem_hillshade_3x3_unit_assert.svh
// Assertion macros for the hillshade RTL.
// Included by modules that check their own logic; no other dependencies.
`ifndef DEM_HILLSHADE_3X3_UNIT_ASSERT_SVH
`define DEM_HILLSHADE_3X3_UNIT_ASSERT_SVH

// Same-cycle implication under reset.
`define DH3_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under reset.
`define DH3_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/dh3_pkg.sv
// Shared types and constants for the 3x3 hillshade unit.
// No dependencies.
package dh3_pkg;
	localparam int ELEV_W     = 24;
	localparam int MAX_WIDTH  = 2048;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int LW_W       = 12;
	localparam int WIDTH_MIN  = 3;
	localparam int ROW_W      = 16;
	localparam int GAIN_W     = 24;
	localparam int ALT_W      = 15;
	localparam int LIGHT_W    = 16;
	localparam int SHADE_W    = 16;
	localparam int GRAD_W     = ELEV_W + 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [SHADE_W-1:0] SHADE_FLAT = 16'd256;
	localparam logic [SHADE_W-1:0] SHADE_MAX  = 16'd65280;
	localparam int Q_SAT = 65024;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_WIDTH    = 3'd0,
		CFG_GRADIENT_GAIN = 3'd1,
		CFG_SIN_ALTITUDE  = 3'd2,
		CFG_COS_ALTITUDE  = 3'd3,
		CFG_SIN_LIGHT     = 3'd4,
		CFG_COS_LIGHT     = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [LW_W-1:0]           line_width;
		logic [GAIN_W-1:0]         gradient_gain;
		logic [ALT_W-1:0]          sin_altitude;
		logic [ALT_W-1:0]          cos_altitude;
		logic signed [LIGHT_W-1:0] sin_light;
		logic signed [LIGHT_W-1:0] cos_light;
	} cfg_t;

	typedef struct packed {
		logic                     window_ready;
		logic                     missing;
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;
endpackage

// File: rtl/dh3_if.sv
// Stream channel interfaces for samples in and shade results out.
// Depends on dh3_pkg for field widths.
interface dh3_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [dh3_pkg::ELEV_W-1:0] elevation;
	logic                              sample_missing;
	logic                              frame_start;
	modport source(output valid, elevation, sample_missing, frame_start, input ready);
	modport sink(input valid, elevation, sample_missing, frame_start, output ready);
endinterface

interface dh3_out_if;
	logic                        valid;
	logic                        ready;
	logic                        window_ready;
	logic                        shade_missing;
	logic [dh3_pkg::SHADE_W-1:0] shade;
	modport source(output valid, window_ready, shade_missing, shade, input ready);
	modport sink(input valid, window_ready, shade_missing, shade, output ready);
endinterface

// File: rtl/dh3_front.sv
// Front end: line stores, 3x3 window, position tracking and Horn gradients.
// Depends on dh3_pkg and dh3_if; pushes one job per sample into the queue.
module dh3_front (
	input  logic            clk,
	input  logic            arst_n,
	dh3_in_if.sink          sample_in,
	input  dh3_pkg::cfg_t   cfg,
	output logic            push,
	output dh3_pkg::job_t   job,
	input  logic            full
);
	typedef enum logic [1:0] {F_IDLE, F_SHIFT, F_PUSH} fstate_t;

	fstate_t                        state_q;
	logic [dh3_pkg::ADDR_W-1:0]     col_q;
	logic [dh3_pkg::ROW_W-1:0]      row_q;
	logic [dh3_pkg::ADDR_W-1:0]     addr_q;
	logic [dh3_pkg::ELEV_W:0]       cur_q;
	logic                           rdy_q;
	logic [dh3_pkg::ELEV_W:0]       win_q [9];
	logic [dh3_pkg::ELEV_W:0]       up_rd_s1;
	logic [dh3_pkg::ELEV_W:0]       mid_rd_s1;
	logic [dh3_pkg::ELEV_W:0]       upper_mem  [dh3_pkg::MAX_WIDTH];
	logic [dh3_pkg::ELEV_W:0]       middle_mem [dh3_pkg::MAX_WIDTH];

	logic                           accept;
	logic [dh3_pkg::ADDR_W-1:0]     col_eff;
	logic [dh3_pkg::ROW_W-1:0]      row_eff;
	logic [dh3_pkg::ADDR_W:0]       col_inc;
	logic [dh3_pkg::LW_W-1:0]       lw;
	logic signed [dh3_pkg::GRAD_W-1:0] e [9];
	logic                           any_missing;

	assign sample_in.ready = (state_q == F_IDLE);
	assign accept = sample_in.valid && sample_in.ready;

	always_comb begin
		col_eff = sample_in.frame_start ? '0 : col_q;
		row_eff = sample_in.frame_start ? '0 : row_q;
		col_inc = {1'b0, col_eff} + 1'b1;
		if (cfg.line_width < dh3_pkg::LW_W'(dh3_pkg::WIDTH_MIN)) begin
			lw = dh3_pkg::LW_W'(dh3_pkg::WIDTH_MIN);
		end else if (cfg.line_width > dh3_pkg::LW_W'(dh3_pkg::MAX_WIDTH)) begin
			lw = dh3_pkg::LW_W'(dh3_pkg::MAX_WIDTH);
		end else begin
			lw = cfg.line_width;
		end
	end

	always_comb begin
		any_missing = 1'b0;
		for (int i = 0; i < 9; i++) begin
			e[i] = {{(dh3_pkg::GRAD_W - dh3_pkg::ELEV_W){win_q[i][dh3_pkg::ELEV_W-1]}},
				win_q[i][dh3_pkg::ELEV_W-1:0]};
			any_missing = any_missing | win_q[i][dh3_pkg::ELEV_W];
		end
		job.window_ready = rdy_q;
		job.missing      = any_missing;
		job.gx = (e[0] + (e[3] <<< 1) + e[6]) - (e[2] + (e[5] <<< 1) + e[8]);
		job.gy = (e[6] + (e[7] <<< 1) + e[8]) - (e[0] + (e[1] <<< 1) + e[2]);
	end

	assign push = (state_q == F_PUSH) && !full;

	// line stores: read on accept, write back the shifted column in the following cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			up_rd_s1  <= upper_mem[col_eff];
			mid_rd_s1 <= middle_mem[col_eff];
		end
		if (state_q == F_SHIFT) begin
			upper_mem[addr_q]  <= mid_rd_s1;
			middle_mem[addr_q] <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						cur_q  <= {sample_in.sample_missing, sample_in.elevation};
						addr_q <= col_eff;
						rdy_q  <= (col_eff >= dh3_pkg::ADDR_W'(2)) &&
							(row_eff >= dh3_pkg::ROW_W'(2));
						if (dh3_pkg::LW_W'(col_inc) >= lw) begin
							col_q <= '0;
							row_q <= (row_eff == '1) ? row_eff : row_eff + 1'b1;
						end else begin
							col_q <= col_inc[dh3_pkg::ADDR_W-1:0];
							row_q <= row_eff;
						end
						state_q <= F_SHIFT;
					end
				end
				F_SHIFT: begin
					for (int i = 0; i < 3; i++) begin
						win_q[i*3]   <= win_q[i*3+1];
						win_q[i*3+1] <= win_q[i*3+2];
					end
					win_q[2] <= up_rd_s1;
					win_q[5] <= mid_rd_s1;
					win_q[8] <= cur_q;
					state_q  <= F_PUSH;
				end
				F_PUSH: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/dh3_job_queue.sv
// Two-entry job queue between front end and shading back end.
// Depends on dh3_pkg for the job and status types.
module dh3_job_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dh3_pkg::job_t       job_in,
	input  logic                pop,
	output dh3_pkg::job_t       job_out,
	output dh3_pkg::fifo_stat_t stat
);
	dh3_pkg::job_t mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	assign job_out    = mem_q[rd_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// File: rtl/dh3_back.sv
// Back end: gain, normalize, light projection, square root and division.
// Depends on dh3_pkg, dh3_if and the assertion macro header.
`include "dem_hillshade_3x3_unit_assert.svh"
module dh3_back (
	input  logic          clk,
	input  logic          arst_n,
	input  dh3_pkg::cfg_t cfg,
	input  dh3_pkg::job_t job,
	input  logic          empty,
	output logic          pop,
	dh3_out_if.source     result_out
);
	localparam int PROD_W = dh3_pkg::GRAD_W + dh3_pkg::GAIN_W + 1;
	localparam int T_W    = 49;
	localparam int N_W    = 52;
	localparam int NUM_W  = 59;
	localparam int DIV_W  = 40;

	typedef enum logic [3:0] {
		B_IDLE, B_MULX, B_MULY, B_MAG, B_NORM, B_TMUL1, B_TMUL2, B_NMUL1,
		B_NMUL2, B_CHECK, B_SQX, B_SQY, B_SQRT, B_DINIT, B_DIV, B_DONE
	} bstate_t;

	bstate_t                          state_q;
	logic signed [dh3_pkg::GRAD_W-1:0] gx_q, gy_q;
	logic signed [PROD_W-1:0]         x_q, y_q;
	logic [PROD_W-1:0]                mx_q, my_q;
	logic                             xneg_q, yneg_q;
	logic [4:0]                       s_q;
	logic signed [T_W-1:0]            t_q;
	logic signed [N_W-1:0]            n_q;
	logic [63:0]                      sq_q, r_q, bit_q;
	logic [NUM_W-1:0]                 num_q, quo_q;
	logic [DIV_W-1:0]                 div_q, rem_q;
	logic [5:0]                       cnt_q;
	logic                             out_valid_q, out_rdy_q, out_miss_q;
	logic [dh3_pkg::SHADE_W-1:0]      out_shade_q;

	logic signed [31:0]               xs_w, ys_w;
	logic [16:0]                      k_w;
	logic [63:0]                      kk_w;
	logic signed [T_W-16:0]           t16_w;
	logic [DIV_W:0]                   rem_sh;
	logic                             ge_w;

	assign result_out.valid         = out_valid_q;
	assign result_out.window_ready  = out_rdy_q;
	assign result_out.shade_missing = out_miss_q;
	assign result_out.shade         = out_shade_q;

	assign pop = (state_q == B_IDLE) && !empty && !out_valid_q;

	always_comb begin
		xs_w   = xneg_q ? -(32'(mx_q[30:0])) : 32'(mx_q[30:0]);
		ys_w   = yneg_q ? -(32'(my_q[30:0])) : 32'(my_q[30:0]);
		k_w    = (s_q <= 5'd16) ? (17'd1 << (5'd16 - s_q)) : '0;
		kk_w   = (s_q <= 5'd16) ? (64'd1 << {(5'd16 - s_q), 1'b0}) : '0;
		t16_w  = t_q[T_W-1:15];
		rem_sh = {rem_q, num_q[NUM_W-1]};
		ge_w   = rem_sh >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (result_out.valid && result_out.ready) out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (!job.window_ready || job.missing) begin
							out_valid_q <= 1'b1;
							out_rdy_q   <= job.window_ready;
							out_miss_q  <= 1'b1;
							out_shade_q <= '0;
						end else begin
							gx_q    <= job.gx;
							gy_q    <= job.gy;
							state_q <= B_MULX;
						end
					end
				end
				B_MULX: begin
					x_q     <= gx_q * $signed({1'b0, cfg.gradient_gain});
					state_q <= B_MULY;
				end
				B_MULY: begin
					y_q     <= gy_q * $signed({1'b0, cfg.gradient_gain});
					state_q <= B_MAG;
				end
				B_MAG: begin
					xneg_q  <= x_q[PROD_W-1];
					yneg_q  <= y_q[PROD_W-1];
					mx_q    <= x_q[PROD_W-1] ? -x_q : x_q;
					my_q    <= y_q[PROD_W-1] ? -y_q : y_q;
					s_q     <= '0;
					state_q <= B_NORM;
				end
				// shift both magnitudes until the larger fits in 31 bits
				B_NORM: begin
					if ((mx_q[PROD_W-1:31] != '0) || (my_q[PROD_W-1:31] != '0)) begin
						mx_q <= mx_q >> 1;
						my_q <= my_q >> 1;
						s_q  <= s_q + 1'b1;
					end else begin
						state_q <= B_TMUL1;
					end
				end
				B_TMUL1: begin
					t_q     <= ys_w * cfg.cos_light;
					state_q <= B_TMUL2;
				end
				B_TMUL2: begin
					t_q     <= t_q + xs_w * cfg.sin_light;
					state_q <= B_NMUL1;
				end
				B_NMUL1: begin
					n_q     <= $signed(N_W'(cfg.sin_altitude * k_w));
					state_q <= B_NMUL2;
				end
				B_NMUL2: begin
					n_q     <= n_q + $signed({1'b0, cfg.cos_altitude}) * t16_w;
					state_q <= B_CHECK;
				end
				B_CHECK: begin
					if (n_q[N_W-1] || (n_q == '0)) begin
						out_valid_q <= 1'b1;
						out_rdy_q   <= 1'b1;
						out_miss_q  <= 1'b0;
						out_shade_q <= dh3_pkg::SHADE_FLAT;
						state_q     <= B_IDLE;
					end else begin
						state_q <= B_SQX;
					end
				end
				B_SQX: begin
					sq_q    <= kk_w + 64'(mx_q[30:0]) * 64'(mx_q[30:0]);
					state_q <= B_SQY;
				end
				B_SQY: begin
					sq_q    <= sq_q + 64'(my_q[30:0]) * 64'(my_q[30:0]);
					r_q     <= '0;
					bit_q   <= 64'd1 << 62;
					state_q <= B_SQRT;
				end
				// one result bit per cycle
				B_SQRT: begin
					if (sq_q >= r_q + bit_q) begin
						sq_q <= sq_q - (r_q + bit_q);
						r_q  <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) state_q <= B_DINIT;
				end
				B_DINIT: begin
					num_q   <= (NUM_W'(n_q[N_W-2:0]) << 8) - (NUM_W'(n_q[N_W-2:0]) << 1)
						+ (NUM_W'(r_q[32:0]) << 6);
					div_q   <= DIV_W'(r_q[32:0]) << 7;
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= 6'(NUM_W - 1);
					state_q <= B_DIV;
				end
				// restoring division, one quotient bit per cycle
				B_DIV: begin
					rem_q   <= ge_w ? DIV_W'(rem_sh - {1'b0, div_q}) : rem_sh[DIV_W-1:0];
					quo_q   <= {quo_q[NUM_W-2:0], ge_w};
					num_q   <= num_q << 1;
					cnt_q   <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= B_DONE;
				end
				B_DONE: begin
					out_valid_q <= 1'b1;
					out_rdy_q   <= 1'b1;
					out_miss_q  <= 1'b0;
					out_shade_q <= (quo_q > NUM_W'(dh3_pkg::Q_SAT)) ? dh3_pkg::SHADE_MAX :
						dh3_pkg::SHADE_W'(quo_q) + dh3_pkg::SHADE_FLAT;
					state_q     <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`DH3_ASSERT_IMP(a_missing_zero, clk, arst_n,
		out_valid_q && out_miss_q, out_shade_q == '0, "nodata result with nonzero shade")
	`DH3_ASSERT_IMP(a_shade_range, clk, arst_n, out_valid_q && !out_miss_q,
		out_shade_q >= dh3_pkg::SHADE_FLAT && out_shade_q <= dh3_pkg::SHADE_MAX,
		"shade out of range")
	`DH3_ASSERT_IMP(a_edge_missing, clk, arst_n,
		out_valid_q && !out_rdy_q, out_miss_q, "edge window not flagged nodata")
	`DH3_ASSERT_NEXT(a_pop_progress, clk, arst_n,
		pop, (state_q != B_IDLE) || out_valid_q, "popped job was dropped")
endmodule

// File: rtl/dem_hillshade_3x3_unit.sv
// Top level of the streaming 3x3 Horn hillshade unit with config registers.
// Depends on dh3_pkg, dh3_if, dh3_front, dh3_job_queue and dh3_back.
//
//  channel     | dir | handshake      | beat
//  sample_in   | in  | valid / ready  | elevation, sample_missing, frame_start
//  result_out  | out | valid / ready  | window_ready, shade_missing, shade
//  cfg         | in  | cfg_we         | cfg_index, cfg_data
//
// The front end reads the line stores, shifts the window and pushes a job per sample,
// waiting while the queue is full. An edge or nodata beat is registered straight from
// idle; a shaded beat runs the gain, normalize loop, light projection, 32-step square
// root and 59-step divider. A two-entry queue lets the front keep taking samples while
// the back end works or while a finished beat waits. No clearing pass after reset.
module dem_hillshade_3x3_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	dh3_in_if.sink                           sample_in,
	dh3_out_if.source                        result_out,
	input  logic                             cfg_we,
	input  logic [dh3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dh3_pkg::CFG_DATA_W-1:0]   cfg_data
);
	dh3_pkg::cfg_t       cfg_q;
	dh3_pkg::job_t       push_job;
	dh3_pkg::job_t       pop_job;
	dh3_pkg::fifo_stat_t q_stat;
	logic                push;
	logic                pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_width    <= dh3_pkg::LW_W'(dh3_pkg::MAX_WIDTH);
			cfg_q.gradient_gain <= 24'd8192;
			cfg_q.sin_altitude  <= 15'd23170;
			cfg_q.cos_altitude  <= 15'd23170;
			cfg_q.sin_light     <= -16'sd23170;
			cfg_q.cos_light     <= -16'sd23170;
		end else if (cfg_we) begin
			case (dh3_pkg::cfg_idx_t'(cfg_index))
				dh3_pkg::CFG_LINE_WIDTH:    cfg_q.line_width    <= cfg_data[dh3_pkg::LW_W-1:0];
				dh3_pkg::CFG_GRADIENT_GAIN: cfg_q.gradient_gain <= cfg_data[dh3_pkg::GAIN_W-1:0];
				dh3_pkg::CFG_SIN_ALTITUDE:  cfg_q.sin_altitude  <= cfg_data[dh3_pkg::ALT_W-1:0];
				dh3_pkg::CFG_COS_ALTITUDE:  cfg_q.cos_altitude  <= cfg_data[dh3_pkg::ALT_W-1:0];
				dh3_pkg::CFG_SIN_LIGHT:     cfg_q.sin_light     <= cfg_data[dh3_pkg::LIGHT_W-1:0];
				dh3_pkg::CFG_COS_LIGHT:     cfg_q.cos_light     <= cfg_data[dh3_pkg::LIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	dh3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_in (sample_in),
		.cfg       (cfg_q),
		.push      (push),
		.job       (push_job),
		.full      (q_stat.full)
	);

	dh3_job_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (push_job),
		.pop     (pop),
		.job_out (pop_job),
		.stat    (q_stat)
	);

	dh3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.job        (pop_job),
		.empty      (q_stat.empty),
		.pop        (pop),
		.result_out (result_out)
	);
endmodule

// File: sim/tb.sv
// Self-checking bench for dem_hillshade_3x3_unit: raster frames of elevation samples
// go in, each shade beat is checked against an in-bench Horn hillshade predictor.
// Depends on dh3_pkg, dh3_if and the unit's RTL.
`timescale 1ns / 1ps

module tb;
	typedef struct {
		logic        window_ready;
		logic        shade_missing;
		logic [15:0] shade;
	} shade_beat_t;

	localparam int CYCLE_LIMIT = 3_000_000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [dh3_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dh3_pkg::CFG_DATA_W-1:0] cfg_data;

	dh3_in_if  samples();
	dh3_out_if shades();

	dem_hillshade_3x3_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_in(samples.sink),
		.result_out(shades.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [dh3_pkg::LW_W-1:0]    p_width;
	logic [dh3_pkg::GAIN_W-1:0]  p_gain;
	logic [dh3_pkg::ALT_W-1:0]   p_sin_alt, p_cos_alt;
	logic [dh3_pkg::LIGHT_W-1:0] p_sin_light, p_cos_light;
	logic [24:0]        p_upper [dh3_pkg::MAX_WIDTH];
	logic [24:0]        p_middle [dh3_pkg::MAX_WIDTH];
	logic [24:0]        p_window [9];
	int unsigned        p_col, p_row;

	shade_beat_t pending_shades[$];
	int failures;
	int samples_sent, shades_seen, shaded_beats;
	longint cycles;
	bit steady;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] horn_shade();
		longint w[9];
		longint gx, gy, g, xv, yv, xs, ys, k, t16, n, cl, sl;
		longint unsigned mx, my, big, d, q;
		int s;
		for (int i = 0; i < 9; i++) w[i] = longint'($signed(p_window[i][23:0]));
		gx = (w[0] + 2 * w[3] + w[6]) - (w[2] + 2 * w[5] + w[8]);
		gy = (w[6] + 2 * w[7] + w[8]) - (w[0] + 2 * w[1] + w[2]);
		g = longint'(p_gain);
		xv = gx * g;
		yv = gy * g;
		mx = xv < 0 ? -xv : xv;
		my = yv < 0 ? -yv : yv;
		big = mx > my ? mx : my;
		s = 0;
		while ((big >> s) >= 64'h8000_0000) s++;
		xs = xv < 0 ? -longint'(mx >> s) : longint'(mx >> s);
		ys = yv < 0 ? -longint'(my >> s) : longint'(my >> s);
		k = s <= 16 ? (longint'(1) << (16 - s)) : 0;
		cl = longint'($signed(p_cos_light));
		sl = longint'($signed(p_sin_light));
		t16 = (ys * cl + xs * sl) >>> 15;
		n = longint'(p_sin_alt) * k + longint'(p_cos_alt) * t16;
		if (n <= 0) return dh3_pkg::SHADE_FLAT;
		d = int_sqrt(longint'(k * k) + longint'(xs * xs) + longint'(ys * ys));
		q = (longint'(n) * 254 + 64 * d) / (128 * d);
		if (q > dh3_pkg::Q_SAT) return dh3_pkg::SHADE_MAX;
		return 16'(256 + q);
	endfunction

	function automatic shade_beat_t shade_step(logic [23:0] elev, logic miss, logic fs);
		shade_beat_t r;
		logic [24:0] cur;
		int unsigned w;
		bit any_missing;
		cur = {miss, elev};
		w = p_width < dh3_pkg::WIDTH_MIN ? dh3_pkg::WIDTH_MIN :
			(p_width > dh3_pkg::MAX_WIDTH ? dh3_pkg::MAX_WIDTH : p_width);
		if (fs) begin
			p_col = 0;
			p_row = 0;
		end
		for (int i = 0; i < 3; i++) begin
			p_window[i * 3]     = p_window[i * 3 + 1];
			p_window[i * 3 + 1] = p_window[i * 3 + 2];
		end
		p_window[2] = p_upper[p_col];
		p_window[5] = p_middle[p_col];
		p_window[8] = cur;
		p_upper[p_col] = p_middle[p_col];
		p_middle[p_col] = cur;
		any_missing = 0;
		for (int i = 0; i < 9; i++) if (p_window[i][24]) any_missing = 1;
		r.window_ready = p_col >= 2 && p_row >= 2;
		if (!r.window_ready || any_missing) begin
			r.shade_missing = 1'b1;
			r.shade = '0;
		end else begin
			r.shade_missing = 1'b0;
			r.shade = horn_shade();
		end
		p_col++;
		if (p_col >= w) begin
			p_col = 0;
			if (p_row < 65535) p_row++;
		end
		return r;
	endfunction

	// result side: random stalls per beat, occasionally none at all
	initial begin
		int n;
		shades.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = steady ? 0 : $urandom_range(0, 14);
			if (n > 0) begin
				shades.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			shades.ready <= 1'b1;
			do @(posedge clk); while (!shades.valid);
		end
	end

	always @(posedge clk) begin
		shade_beat_t exp_beat;
		if (arst_n && shades.valid && shades.ready) begin
			shades_seen++;
			if (pending_shades.size() == 0) begin
				$error("shade beat with nothing expected");
				failures++;
			end else begin
				exp_beat = pending_shades.pop_front();
				if (!exp_beat.shade_missing) shaded_beats++;
				if (shades.window_ready !== exp_beat.window_ready) begin
					$error("window_ready expected %0b got %0b",
						exp_beat.window_ready, shades.window_ready);
					failures++;
				end
				if (shades.shade_missing !== exp_beat.shade_missing) begin
					$error("shade_missing expected %0b got %0b",
						exp_beat.shade_missing, shades.shade_missing);
					failures++;
				end
				if (shades.shade !== exp_beat.shade) begin
					$error("shade expected %0d got %0d", exp_beat.shade, shades.shade);
					failures++;
				end
			end
		end
	end

	task automatic send_sample(logic [23:0] elev, logic miss, logic fs);
		int n;
		n = steady ? 0 : $urandom_range(0, 14);
		if (n > 0) begin
			samples.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.elevation <= elev;
		samples.sample_missing <= miss;
		samples.frame_start <= fs;
		do @(posedge clk); while (!samples.ready);
		pending_shades.push_back(shade_step(elev, miss, fs));
		samples_sent++;
		if ($urandom_range(0, 40) == 0) steady = !steady;
	endtask

	// hold input idle until every expected beat is back
	task automatic drain();
		samples.valid <= 1'b0;
		while (pending_shades.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(logic [11:0] lw, logic [23:0] gain, logic [14:0] sa,
			logic [14:0] ca, logic [15:0] sl, logic [15:0] cl);
		logic [23:0] vals[6];
		vals = '{24'(lw), gain, 24'(sa), 24'(ca), 24'(sl), 24'(cl)};
		drain();
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= dh3_pkg::CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		p_width = lw;
		p_gain = gain;
		p_sin_alt = sa;
		p_cos_alt = ca;
		p_sin_light = sl;
		p_cos_light = cl;
	endtask

	// one frame: smooth terrain with random slope, a few missing and wild samples, random restarts
	task automatic run_frame(int unsigned width, int unsigned rows, int unsigned tail);
		int base, sx, sy;
		logic [23:0] e;
		logic m;
		base = $urandom_range(0, 200000) - 100000;
		sx = $urandom_range(0, 2000) - 1000;
		sy = $urandom_range(0, 2000) - 1000;
		for (int unsigned i = 0; i < width * rows + tail; i++) begin
			e = 24'(base + sx * int'(i % width) + sy * int'(i / width)
				+ $urandom_range(0, 64) - 32);
			if ($urandom_range(0, 19) == 0) e = 24'($urandom);
			m = $urandom_range(0, 39) == 0;
			send_sample(e, m, i == 0 || $urandom_range(0, 299) == 0);
		end
	endtask

	task automatic test_reset_width();
		steady = 1;
		run_frame(dh3_pkg::MAX_WIDTH, 0, 250);
		steady = 0;
	endtask

	task automatic test_directed_extremes();
		logic [23:0] ext[4];
		ext = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF};
		write_regs(12'd0, 24'hFFFFFF, 15'h7FFF, 15'h7FFF, 16'h8001, 16'h7FFF);
		for (int i = 0; i < 12; i++)
			send_sample(ext[(i * 3 + i / 3) % 4], 1'b0, i == 0);
		write_regs(12'd1, 24'd0, 15'd0, 15'd0, 16'h7FFF, 16'h8000);
		for (int i = 0; i < 4; i++) send_sample(24'(i * 5), 1'b0, i == 0);
		// a restart mid-row, then nodata inside a window
		write_regs(12'd2, 24'd8192, 15'd23170, 15'd23170, 16'hA57E, 16'hA57E);
		for (int i = 0; i < 11; i++)
			send_sample(24'(i * i * 40), i == 7, i == 0 || i == 5);
	endtask

	task automatic test_wide_clamp();
		write_regs(12'hFFF, 24'd65536, 15'd16384, 15'd28378, 16'd0, 16'h8001);
		steady = 1;
		run_frame(dh3_pkg::MAX_WIDTH, 0, 250);
		steady = 0;
	endtask

	task automatic test_random_frames();
		int unsigned w;
		logic [23:0] gain;
		while (samples_sent < 1850) begin
			w = $urandom_range(0, 9) == 0 ? $urandom_range(3, 48) : $urandom_range(3, 8);
			case ($urandom_range(0, 3))
				0: gain = 24'($urandom_range(0, 24'hFFFFFF));
				1: gain = 24'($urandom_range(0, 255));
				default: gain = 24'($urandom_range(256, 65536));
			endcase
			write_regs(12'(w), gain, 15'($urandom), 15'($urandom),
				16'($urandom), 16'($urandom));
			run_frame(w, $urandom_range(3, 7), $urandom_range(0, w));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples.valid = 1'b0;
		samples.elevation = '0;
		samples.sample_missing = 1'b0;
		samples.frame_start = 1'b0;
		cycles = 0;
		failures = 0;
		samples_sent = 0;
		shades_seen = 0;
		shaded_beats = 0;
		steady = 0;
		p_width = 12'd2048;
		p_gain = 24'd8192;
		p_sin_alt = 15'd23170;
		p_cos_alt = 15'd23170;
		p_sin_light = -16'sd23170;
		p_cos_light = -16'sd23170;
		p_col = 0;
		p_row = 0;
		for (int i = 0; i < dh3_pkg::MAX_WIDTH; i++) begin
			p_upper[i] = '0;
			p_middle[i] = '0;
		end
		for (int i = 0; i < 9; i++) p_window[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_width();
		test_directed_extremes();
		test_wide_clamp();
		test_random_frames();
		drain();
		repeat (200) @(posedge clk);

		$display("%0d samples sent, %0d beats checked, %0d of them shaded",
			samples_sent, shades_seen, shaded_beats);
		$display("covered clamped widths, extreme gain and trig, nodata and frame restarts");
		if (failures == 0 && pending_shades.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
